// File: src/s2l_pkg.sv
// Shared constants, tables and types for the sRGB to CIELAB converter.
package s2l_pkg;

   // Number of segments in the cube root table (256 to 4096).
   localparam int CBRT_DEPTH = 1024;
   localparam int CBRT_IDX_W = $clog2(CBRT_DEPTH + 1);
   localparam int CBRT_DEPTH_W = $clog2(CBRT_DEPTH + 1);

   localparam int LIN_W = 16;
   localparam int PROD_W = 40;
   localparam int NUM_W = 40;
   localparam int T_W = 17;
   localparam int F_W = 18;
   localparam int FR_W = 18;

   localparam int NUM_CH = 3;

   typedef logic [23:0] coef_row_type [NUM_CH];
   typedef coef_row_type coef_matrix_type [NUM_CH];

   // Matrix coefficients scaled by 1e7; row is X, Y, Z and column is R, G, B.
   localparam coef_matrix_type COEF = '{
      '{24'd4124564, 24'd3575761, 24'd1804375},
      '{24'd2126729, 24'd7151522, 24'd721750},
      '{24'd193339,  24'd1191920, 24'd9503041}
   };

   typedef logic [23:0] div_array_type [NUM_CH];
   typedef logic [21:0] recip_array_type [NUM_CH];

   // White normalization divides the row sum by these, rounding to nearest.
   localparam div_array_type DIVISOR = '{24'd9504000, 24'd10000000, 24'd10888000};
   localparam div_array_type HALF_DIV = '{24'd4752000, 24'd5000000, 24'd5444000};
   localparam recip_array_type RECIP = '{
      22'((64'd1 << 45) / 64'd9504000),
      22'((64'd1 << 45) / 64'd10000000),
      22'((64'd1 << 45) / 64'd10888000)
   };

   // Linear pivot branch: floor((9033*t + 10486340) / 1160) via a reciprocal.
   localparam longint unsigned LIN_M = ((64'd1 << 35) + 64'd1159) / 64'd1160;
   localparam logic [37:0] LIN_A = 38'(64'd9033 * LIN_M);
   localparam logic [49:0] LIN_B = 50'(64'd10486340 * LIN_M);
   localparam logic [T_W-1:0] PIVOT_KNEE = 17'd580;

   typedef logic [LIN_W-1:0] lin_table_type [256];
   typedef logic [16:0] cbrt_table_type [CBRT_DEPTH + 1];

   function automatic longint unsigned mul_q30(longint unsigned x, longint unsigned y);
      return (x * y) >> 30;
   endfunction

   function automatic lin_table_type build_lin_table();
      lin_table_type tbl;
      longint unsigned q, s2, lo, hi, mid, pw, res;
      for (int v = 0; v < 256; v++) begin
         if (v <= 10) begin
            tbl[v] = LIN_W'((longint'(v) * 6553600 + 164730) / 329460);
         end else begin
            q = ((64'd1000 * longint'(v) + 64'd14025) << 30) / 64'd269025;
            s2 = mul_q30(q, q);
            lo = 0;
            hi = 64'd1 << 30;
            while (lo < hi) begin
               mid = lo + (hi - lo + 1) / 2;
               pw = mid;
               for (int k = 0; k < 4; k++) begin
                  pw = mul_q30(pw, mid);
               end
               if (pw <= s2) begin
                  lo = mid;
               end else begin
                  hi = mid - 1;
               end
            end
            res = (mul_q30(s2, lo) + 8192) >> 14;
            tbl[v] = (res > 65535) ? 16'hFFFF : LIN_W'(res);
         end
      end
      return tbl;
   endfunction

   function automatic cbrt_table_type build_cbrt_table();
      cbrt_table_type tbl;
      longint unsigned lo, hi, mid, lim;
      for (int i = 0; i <= CBRT_DEPTH; i++) begin
         lo = 0;
         hi = 65536;
         lim = longint'(i) << 48;
         while (lo < hi) begin
            mid = lo + (hi - lo + 1) / 2;
            if (mid * mid * mid * longint'(CBRT_DEPTH) <= lim) begin
               lo = mid;
            end else begin
               hi = mid - 1;
            end
         end
         tbl[i] = 17'(lo);
      end
      return tbl;
   endfunction

   localparam lin_table_type LIN_TABLE = build_lin_table();
   localparam cbrt_table_type CBRT_TABLE = build_cbrt_table();

endpackage

// File: src/srgb_to_lab_converter.sv
// Top level of the sRGB to CIELAB (D65) pixel converter pipeline.
//
//   Channel  Direction  Handshake           Payload
//   req      in         req_valid/stall     red, green, blue (8 bits each)
//   rsp      out        rsp_valid/stall     lightness, a_star, b_star
//
// One pixel enters per clock while no valid result is stalled at the output.
// The pipeline runs through linearization, matrix, normalization
// divide (four stages), pivot (four stages) and the Lab output stages.
// Reset clears every valid bit; data registers are not reset.
// A stalled valid result freezes the whole pipeline, so req_stall is raised only then.
module srgb_to_lab_converter (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_red,
   input  logic [7:0]  req_green,
   input  logic [7:0]  req_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [14:0] rsp_lightness,
   output logic signed [15:0] rsp_a_star,
   output logic signed [15:0] rsp_b_star
);
   import s2l_pkg::*;

   localparam int NUM_STG = 11;

   logic                  enable;
   logic [NUM_STG-1:0]    valid_ff;
   logic [NUM_STG-1:0]    valid_in;
   logic                  rsp_valid_ff;

   logic [LIN_W-1:0]      lin_ff   [NUM_CH];
   logic [PROD_W-1:0]     prod_ff  [NUM_CH][NUM_CH];
   logic [NUM_W-1:0]      num_ff   [NUM_CH];
   logic [NUM_W-1:0]      num2_ff  [NUM_CH];
   logic [NUM_W-1:0]      num3_ff  [NUM_CH];
   logic [T_W-1:0]        q0_ff    [NUM_CH];
   logic [T_W-1:0]        q0b_ff   [NUM_CH];
   logic [40:0]           qd_ff    [NUM_CH];
   logic [T_W-1:0]        t_ff     [NUM_CH];
   logic [F_W-1:0]        f_out    [NUM_CH];

   logic [NUM_W-1:0]      num_in   [NUM_CH];
   logic [48:0]           est_in   [NUM_CH];
   logic [40:0]           rem_in   [NUM_CH];
   logic [T_W-1:0]        t_in     [NUM_CH];

   logic signed [29:0]    l_prod_ff, a_prod_ff, b_prod_ff;
   logic signed [29:0]    l_prod_in, a_prod_in, b_prod_in;
   logic signed [21:0]    l_rnd, a_rnd, b_rnd;
   logic [14:0]           l_ff, l_in;
   logic signed [15:0]    a_ff, b_ff, a_in, b_in;

   assign enable = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;
   assign valid_in = {valid_ff[NUM_STG-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff     <= valid_in;
         rsp_valid_ff <= valid_ff[NUM_STG-1];
      end
   end

   always_comb begin
      for (int c = 0; c < NUM_CH; c++) begin
         num_in[c] = NUM_W'(42'(prod_ff[c][0]) + 42'(prod_ff[c][1]) + 42'(prod_ff[c][2])
                     + 42'(HALF_DIV[c]));
         est_in[c] = 49'(num_ff[c][NUM_W-1:13]) * 49'(RECIP[c]);
         rem_in[c] = 41'(num3_ff[c]) - qd_ff[c];
         // The quotient estimate is low by at most two.
         if (rem_in[c] >= 41'(DIVISOR[c]) * 41'd2) begin
            t_in[c] = q0b_ff[c] + T_W'(2);
         end else if (rem_in[c] >= 41'(DIVISOR[c])) begin
            t_in[c] = q0b_ff[c] + T_W'(1);
         end else begin
            t_in[c] = q0b_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         lin_ff[0] <= LIN_TABLE[req_red];
         lin_ff[1] <= LIN_TABLE[req_green];
         lin_ff[2] <= LIN_TABLE[req_blue];
         for (int c = 0; c < NUM_CH; c++) begin
            for (int k = 0; k < NUM_CH; k++) begin
               prod_ff[c][k] <= PROD_W'(lin_ff[k]) * PROD_W'(COEF[c][k]);
            end
            num_ff[c]  <= num_in[c];
            q0_ff[c]   <= est_in[c][48:32];
            num2_ff[c] <= num_ff[c];
            qd_ff[c]   <= 41'(q0_ff[c]) * 41'(DIVISOR[c]);
            q0b_ff[c]  <= q0_ff[c];
            num3_ff[c] <= num2_ff[c];
            t_ff[c]    <= t_in[c];
         end
      end
   end

   for (genvar c = 0; c < NUM_CH; c++) begin : g_pivot
      s2l_pivot u_pivot (
         .clock  (clock),
         .enable (enable),
         .t      (t_ff[c]),
         .f      (f_out[c])
      );
   end

   always_comb begin
      l_prod_in = 30'sd116 * $signed(30'(f_out[1])) - 30'sd1048576;
      a_prod_in = 30'sd500 * ($signed(30'(f_out[0])) - $signed(30'(f_out[1])));
      b_prod_in = 30'sd200 * ($signed(30'(f_out[1])) - $signed(30'(f_out[2])));
      l_rnd = 22'((l_prod_ff + 30'sd128) >>> 8);
      a_rnd = 22'((a_prod_ff + 30'sd128) >>> 8);
      b_rnd = 22'((b_prod_ff + 30'sd128) >>> 8);
      if (l_rnd < 22'sd0) begin
         l_in = '0;
      end else if (l_rnd > 22'sd25600) begin
         l_in = 15'd25600;
      end else begin
         l_in = 15'(l_rnd);
      end
      if (a_rnd < -22'sd32768) begin
         a_in = -16'sd32768;
      end else if (a_rnd > 22'sd32767) begin
         a_in = 16'sd32767;
      end else begin
         a_in = 16'(a_rnd);
      end
      if (b_rnd < -22'sd32768) begin
         b_in = -16'sd32768;
      end else if (b_rnd > 22'sd32767) begin
         b_in = 16'sd32767;
      end else begin
         b_in = 16'(b_rnd);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         l_prod_ff <= l_prod_in;
         a_prod_ff <= a_prod_in;
         b_prod_ff <= b_prod_in;
         l_ff      <= l_in;
         a_ff      <= a_in;
         b_ff      <= b_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_lightness = l_ff;
   assign rsp_a_star    = a_ff;
   assign rsp_b_star    = b_ff;

   a_stall_only_on_output: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a stalled result");

   a_lightness_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_lightness <= 15'd25600))
      else $error("lightness above its range");

   a_reset_empties: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_pipe_advance: assert property (@(posedge clock) disable iff (reset)
      (valid_ff[NUM_STG-1] && !req_stall) |=> rsp_valid)
      else $error("last stage lost a transaction");

endmodule

// File: src/s2l_pivot.sv
// Four-stage CIE pivot: cube root by table interpolation, linear below the knee.
module s2l_pivot (
   input  logic                    clock,
   input  logic                    enable,
   input  logic [s2l_pkg::T_W-1:0] t,
   output logic [s2l_pkg::F_W-1:0] f
);
   import s2l_pkg::*;

   localparam int P_W = T_W + CBRT_DEPTH_W;

   logic [P_W-1:0]        p;
   logic [P_W-17:0]       i_raw;
   logic [CBRT_IDX_W-1:0] i_sel;
   logic [P_W-1:0]        fr_full;
   logic [49:0]           lin_num;

   logic                  is_lin_ff, is_lin2_ff, is_lin3_ff;
   logic [F_W-1:0]        lin_f_ff, lin_f2_ff, lin_f3_ff;
   logic [CBRT_IDX_W-1:0] idx_ff;
   logic [FR_W-1:0]       fr_ff, fr2_ff;
   logic [16:0]           e0_ff, e1_ff, e0b_ff;
   logic [35:0]           slope_ff;
   logic [F_W-1:0]        f_ff;
   logic [35:0]           slope_in;
   logic [F_W-1:0]        f_in;

   always_comb begin
      p = P_W'(t) * P_W'(CBRT_DEPTH);
      i_raw = p[P_W-1:16];
      if (i_raw > (P_W-16)'(CBRT_DEPTH - 1)) begin
         i_sel = CBRT_IDX_W'(CBRT_DEPTH - 1);
      end else begin
         i_sel = CBRT_IDX_W'(i_raw);
      end
      fr_full = p - (P_W'(i_sel) << 16);
      lin_num = LIN_A * 50'(t[9:0]) + LIN_B;
   end

   always_comb begin
      slope_in = 36'(e1_ff - e0_ff) * 36'(fr2_ff);
      if (is_lin3_ff) begin
         f_in = lin_f3_ff;
      end else begin
         f_in = F_W'(e0b_ff) + F_W'((slope_ff + 36'd32768) >> 16);
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         // Stage one: segment index, fraction and the linear branch.
         is_lin_ff <= (t <= PIVOT_KNEE);
         lin_f_ff  <= F_W'(lin_num >> 35);
         idx_ff    <= i_sel;
         fr_ff     <= fr_full[FR_W-1:0];
         // Stage two: table reads at both ends of the segment.
         e0_ff      <= CBRT_TABLE[idx_ff];
         e1_ff      <= CBRT_TABLE[idx_ff + 1'b1];
         fr2_ff     <= fr_ff;
         is_lin2_ff <= is_lin_ff;
         lin_f2_ff  <= lin_f_ff;
         // Stage three: slope times fraction.
         slope_ff   <= slope_in;
         e0b_ff     <= e0_ff;
         is_lin3_ff <= is_lin2_ff;
         lin_f3_ff  <= lin_f2_ff;
         // Stage four: final value.
         f_ff <= f_in;
      end
   end

   assign f = f_ff;

endmodule
